>>> rtl/bfa_pkg.sv
// Shared types, constants and helpers of the bitstring field access unit.
`default_nettype none

package bfa_pkg;

    // Store geometry
    localparam int STORE_BYTES_DEF = 1024;
    localparam int NUM_BANKS       = 8;
    localparam int BANK_SEL_W      = 3;
    localparam int WIN_BYTES       = 5;
    localparam int WIN_W           = 8 * WIN_BYTES;

    // Field geometry
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 13;
    localparam int WIDTH_W = 6;
    localparam int HI_ROW_W = 8;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] bit_index;
        logic [WIDTH_W-1:0] field_width;
        logic [DATA_W-1:0]  write_value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              range_error;
    } rsp_t;

    typedef logic [NUM_BANKS-1:0][7:0] bank_bytes_t;

    // Row of a bank within the five-byte window that starts at the field's byte
    function automatic logic [HI_ROW_W-1:0] win_row(input logic [INDEX_W-1:0] idx,
                                                    input logic [BANK_SEL_W-1:0] bank);
        logic [HI_ROW_W-1:0] base_row;
        logic                wrap;
        base_row = {1'b0, idx[INDEX_W-1:6]};
        wrap     = (bank < idx[5:3]);
        return base_row + {{(HI_ROW_W-1){1'b0}}, wrap};
    endfunction

endpackage

`default_nettype wire

>>> rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfa_clear.sv
// Post-reset clearing sequencer that sweeps every row of the byte banks.
`default_nettype none

module bfa_clear #(
    parameter int ROWS  = 128,
    parameter int ROW_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    output logic                  active,
    output logic      [ROW_W-1:0] row
);

    logic             active_reg, active_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Advance one row per cycle until the last row is written
    always_comb
    begin
        active_next = active_reg;
        row_next    = row_reg;
        if (active_reg)
        begin
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                active_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            row_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            row_reg    <= row_next;
        end
    end

    assign active = active_reg;
    assign row    = row_reg;

endmodule

`default_nettype wire

>>> rtl/bfa_merge.sv
// Window gather, field extract, field insert and byte scatter for one access.
`default_nettype none

module bfa_merge #(
    parameter int STORE_BYTES = bfa_pkg::STORE_BYTES_DEF
) (
    input  wire bfa_pkg::req_t                         req,
    input  wire bfa_pkg::bank_bytes_t                  bank_data,
    output bfa_pkg::rsp_t                              rsp,
    output logic [bfa_pkg::NUM_BANKS-1:0]              wr_en,
    output bfa_pkg::bank_bytes_t                       wr_data
);

    localparam logic [31:0] STORE_BITS = 32'(8 * STORE_BYTES);

    logic [bfa_pkg::WIDTH_W-1:0]    w_sat;
    logic [31:0]                    field_end;
    logic                           range_err;
    logic                           active;
    logic [2:0]                     sh;
    logic [2:0]                     lo;
    logic [bfa_pkg::DATA_W-1:0]     field_mask;
    logic [bfa_pkg::WIN_W-1:0]      win;
    logic [bfa_pkg::WIN_W-1:0]      mask;
    logic [bfa_pkg::WIN_W-1:0]      new_win;
    logic [bfa_pkg::WIN_W-1:0]      picked;
    logic [2:0]                     bsel;
    logic [2:0]                     k;
    logic [5:0]                     pos;

    always_comb
    begin
        // Saturate width and check the field against the store end
        w_sat     = (req.field_width > 6'd32) ? 6'd32 : req.field_width;
        field_end = 32'(req.bit_index) + 32'(w_sat);
        range_err = (field_end > STORE_BITS);
        active    = !range_err && (w_sat != '0);
        sh        = req.bit_index[2:0];
        lo        = req.bit_index[5:3];

        // Gather the five-byte window from the banks
        win = '0;
        for (int i = 0; i < bfa_pkg::WIN_BYTES; i++)
        begin
            bsel = lo + 3'(i);
            win[8*i +: 8] = bank_data[bsel];
        end

        // Build the field mask at its bit offset
        field_mask = 32'hFFFF_FFFF >> (6'd32 - w_sat);
        mask       = {8'h00, field_mask} << sh;

        // Extract on read, merge on write
        picked  = (win & mask) >> sh;
        new_win = (win & ~mask) | (({8'h00, req.write_value} << sh) & mask);

        rsp.range_error = range_err;
        rsp.read_data   = (active && (req.opcode == bfa_pkg::OP_READ))
                          ? picked[bfa_pkg::DATA_W-1:0] : '0;

        // Scatter the merged window back to the banks that hold field bits
        for (int b = 0; b < bfa_pkg::NUM_BANKS; b++)
        begin
            k          = 3'(b) - lo;
            pos        = {k, 3'b000};
            wr_en[b]   = 1'b0;
            wr_data[b] = '0;
            if (k < 3'(bfa_pkg::WIN_BYTES))
            begin
                wr_data[b] = new_win[pos +: 8];
                wr_en[b]   = active && (req.opcode == bfa_pkg::OP_WRITE)
                             && (|mask[pos +: 8]);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bitstring_field_access_unit.sv
// Top level: bit-addressed field store over eight byte-interleaved RAM banks.
// An accepted slave transfer is captured in the stage-1 register, and its result then in
// the output register that drives m_tvalid; a low m_tready can hold either stage.
// Throughput: one access per cycle unless m_tready stalls; a read-modify-write of the
// same bank row in back-to-back accesses is resolved by a bypass register per bank.
// Reset: asynchronous, active low; afterwards a clearing pass zeros one row of all
// banks per cycle over ceil(STORE_BYTES/8) rows (128 at default), with s_tready low.
`default_nettype none

module bitstring_field_access_unit #(
    parameter int STORE_BYTES = bfa_pkg::STORE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // bit_index[12:0], field_width[18:13], write_value[50:19]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // read_data[31:0]
    output logic      [0:0]  m_tuser    // range_error[0]
);

    localparam int NB    = bfa_pkg::NUM_BANKS;
    localparam int ROWS  = (STORE_BYTES + NB - 1) / NB;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    bfa_pkg::req_t          in_req;
    bfa_pkg::req_t          s1_req_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_go;
    logic                   acc;
    logic                   clr_active;
    logic [ROW_W-1:0]       clr_row;

    logic [ROW_W-1:0]       rd_row [NB];
    logic [ROW_W-1:0]       wr_row [NB];
    bfa_pkg::bank_bytes_t   ram_q;
    bfa_pkg::bank_bytes_t   bank_in;
    bfa_pkg::bank_bytes_t   wr_data;
    logic [NB-1:0]          wr_en;
    bfa_pkg::rsp_t          rsp;

    logic [NB-1:0]          byp_hit_reg;
    bfa_pkg::bank_bytes_t   byp_data_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg;
    logic                   out_err_reg;

    // Unpack the slave transfer
    assign in_req.opcode      = s_tuser[0];
    assign in_req.bit_index   = s_tdata[12:0];
    assign in_req.field_width = s_tdata[18:13];
    assign in_req.write_value = s_tdata[50:19];

    // Handshake: stage 1 advances when the output register is free or draining
    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active && (!s1_valid_reg || s1_go);
    assign acc      = s_tvalid && s_tready;

    // Clearing sequencer
    bfa_clear #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (clr_active),
        .row    (clr_row)
    );

    // Bank row addresses for the incoming read and the stage-1 write
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            rd_row[b] = ROW_W'(bfa_pkg::win_row(in_req.bit_index,
                                                bfa_pkg::BANK_SEL_W'(b)));
            wr_row[b] = ROW_W'(bfa_pkg::win_row(s1_req_reg.bit_index,
                                                bfa_pkg::BANK_SEL_W'(b)));
        end
    end

    // Byte banks
    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        bfa_ram #(
            .WIDTH (8),
            .DEPTH (ROWS),
            .AW    (ROW_W)
        ) u_ram (
            .clk   (clk),
            .we    (clr_active || (s1_go && wr_en[b])),
            .waddr (clr_active ? clr_row : wr_row[b]),
            .wdata (clr_active ? 8'h00 : wr_data[b]),
            .re    (acc),
            .raddr (rd_row[b]),
            .rdata (ram_q[b])
        );
    end

    // Replace stale bank data with the write that landed on the same edge as the read
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            bank_in[b] = byp_hit_reg[b] ? byp_data_reg[b] : ram_q[b];
        end
    end

    // Extract and merge
    bfa_merge #(
        .STORE_BYTES (STORE_BYTES)
    ) u_merge (
        .req       (s1_req_reg),
        .bank_data (bank_in),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_data   (wr_data)
    );

    // Stage-1 valid
    always_comb
    begin
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Output valid
    always_comb
    begin
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_hit_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (acc)
            begin
                for (int b = 0; b < NB; b++)
                begin
                    byp_hit_reg[b] <= s1_go && wr_en[b] && (wr_row[b] == rd_row[b]);
                end
            end
        end
    end

    // Payload: capture the request, the bypass bytes and the result
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_req_reg   <= in_req;
            byp_data_reg <= wr_data;
        end
        if (s1_go)
        begin
            out_data_reg <= rsp.read_data;
            out_err_reg  <= rsp.range_error;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

`default_nettype wire
